>>> design/bcgd_pkg.sv
// Shared constants, types and helpers for the button gesture detector.
package bcgd_pkg;

	localparam int TIME_WIDTH       = 32;
	localparam int HOLD_COUNT_WIDTH = 16;
	localparam int WIN_W            = 15;
	localparam int LPT_W            = 16;
	localparam int CFG_DATA_W       = (WIN_W > LPT_W) ? WIN_W : LPT_W;
	localparam int CFG_IDX_W        = 1;
	localparam int HOLD_CMP_W       = ((HOLD_COUNT_WIDTH > LPT_W) ? HOLD_COUNT_WIDTH : LPT_W) + 1;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(400);
	localparam logic [LPT_W-1:0] LPT_RESET = LPT_W'(50);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DBLCLICK_WINDOW  = 1'b0,
		REG_LONG_PRESS_TICKS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic rising;
		logic falling;
		logic click;
		logic double_click;
		logic long_press;
		logic pressed;
	} gesture_t;

	// Saturating increment of the held-tick counter
	function automatic logic [HOLD_COUNT_WIDTH-1:0] held_inc(
		input logic [HOLD_COUNT_WIDTH-1:0] h
	);
		logic [HOLD_COUNT_WIDTH-1:0] r;
		r = (&h) ? h : h + HOLD_COUNT_WIDTH'(1);
		return r;
	endfunction

endpackage

>>> design/bcgd_tracker.sv
// Gesture state and per-tick event decode: one scan tick per enabled cycle.
module bcgd_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                pin_level,
	input  logic [bcgd_pkg::TIME_WIDTH-1:0]     now_ms,
	input  logic [bcgd_pkg::WIN_W-1:0]          dblclick_window_ms,
	input  logic [bcgd_pkg::LPT_W-1:0]          long_press_ticks,
	output bcgd_pkg::gesture_t                  ev
);

	logic                                  prev_q, cur_q, rel_q;
	logic [bcgd_pkg::HOLD_COUNT_WIDTH-1:0] held_q;
	logic [bcgd_pkg::TIME_WIDTH-1:0]       fpt_q;

	logic                                  rel_d, new_pressed;
	logic [bcgd_pkg::HOLD_COUNT_WIDTH-1:0] held_mid, held_lp, held_d;
	logic [bcgd_pkg::TIME_WIDTH-1:0]       fpt_d, elapsed, win_ext;
	logic [bcgd_pkg::HOLD_CMP_W-1:0]       held_mid_x, held_x, lpt_x;
	logic                                  lp_hit;

	assign elapsed     = now_ms - fpt_q;
	assign win_ext     = bcgd_pkg::TIME_WIDTH'(dblclick_window_ms);
	assign held_x      = bcgd_pkg::HOLD_CMP_W'(held_q);
	assign held_mid_x  = bcgd_pkg::HOLD_CMP_W'(held_mid);
	assign lpt_x       = bcgd_pkg::HOLD_CMP_W'(long_press_ticks);
	assign new_pressed = ~pin_level;

	always_comb begin
		ev          = '0;
		rel_d       = rel_q;
		fpt_d       = fpt_q;
		held_mid    = held_q;
		ev.pressed  = new_pressed;
		if (!prev_q && cur_q) begin
			ev.rising = 1'b1;
			if (!rel_q) begin
				fpt_d = now_ms;
			end
		end else if (prev_q && !cur_q) begin
			// a release that ends a long press is not a click
			if (held_x <= lpt_x) begin
				ev.falling = 1'b1;
				if (rel_q) begin
					ev.double_click = (elapsed < win_ext);
					rel_d           = 1'b0;
				end else begin
					rel_d = 1'b1;
				end
			end
			held_mid = '0;
		end else if (rel_q && (elapsed > win_ext)) begin
			ev.click = 1'b1;
			rel_d    = 1'b0;
		end

		lp_hit        = (held_mid_x == lpt_x);
		ev.long_press = lp_hit;
		held_lp       = lp_hit ? bcgd_pkg::held_inc(held_mid) : held_mid;
		held_d        = new_pressed ? bcgd_pkg::held_inc(held_lp) : held_lp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b0;
			cur_q  <= 1'b0;
			rel_q  <= 1'b0;
			held_q <= '0;
			fpt_q  <= '0;
		end else if (step) begin
			prev_q <= cur_q;
			cur_q  <= new_pressed;
			rel_q  <= rel_d;
			held_q <= held_d;
			fpt_q  <= fpt_d;
		end
	end

endmodule

>>> design/button_click_gesture_detector_unit.sv
// Button gesture detector: one scan tick in, one event set out. Ticks are taken one per clock
// cycle with no gaps while the result register is free or drained; a result passes the input
// register, then the gesture decode and state update into the result register. The rate is set
// by the update of the gesture state, which each tick needs before the next. Configuration
// writes take effect at once and must be made only while no tick is in flight.
module button_click_gesture_detector_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bcgd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bcgd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                pin_level,
	input  logic [bcgd_pkg::TIME_WIDTH-1:0]     now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                rising,
	output logic                                falling,
	output logic                                click,
	output logic                                double_click,
	output logic                                long_press,
	output logic                                pressed
);

	logic [bcgd_pkg::WIN_W-1:0]      win_q;
	logic [bcgd_pkg::LPT_W-1:0]      lpt_q;
	logic                            s1_valid_q, out_valid_q, adv, step;
	logic                            pin_s1;
	logic [bcgd_pkg::TIME_WIDTH-1:0] now_s1;
	bcgd_pkg::gesture_t              ev, res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= bcgd_pkg::WIN_RESET;
			lpt_q <= bcgd_pkg::LPT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bcgd_pkg::REG_DBLCLICK_WINDOW:  win_q <= cfg_data[bcgd_pkg::WIN_W-1:0];
				bcgd_pkg::REG_LONG_PRESS_TICKS: lpt_q <= cfg_data[bcgd_pkg::LPT_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipe advances when the result register is free or being drained
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || adv;
	assign step     = s1_valid_q && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
			if (adv) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
			now_s1 <= now_ms;
		end
		if (step) begin
			res_q <= ev;
		end
	end

	bcgd_tracker u_tracker (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (step),
		.pin_level          (pin_s1),
		.now_ms             (now_s1),
		.dblclick_window_ms (win_q),
		.long_press_ticks   (lpt_q),
		.ev                 (ev)
	);

	assign out_valid    = out_valid_q;
	assign rising       = res_q.rising;
	assign falling      = res_q.falling;
	assign click        = res_q.click;
	assign double_click = res_q.double_click;
	assign long_press   = res_q.long_press;
	assign pressed      = res_q.pressed;

endmodule

>>> design/bcgd_checker.sv
// Port-level checks on the gesture detector, bound to the top level.
module bcgd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            rising,
	input logic                            falling,
	input logic                            click,
	input logic                            double_click,
	input logic                            long_press,
	input logic                            pressed
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({rising, falling, click,
			double_click, long_press, pressed}))
		else $error("result changed while stalled");

	a_edges_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(rising && falling))
		else $error("press and release edge in one tick");

	a_dbl_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && double_click |-> falling)
		else $error("double click without counted release");

	a_click_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && click |-> !rising && !falling && !double_click)
		else $error("single click on an edge tick");

endmodule

bind button_click_gesture_detector_unit bcgd_checker u_bcgd_checker (.*);

>>> tb/testbench.sv
// Testbench for the button gesture detector: directed ticks, random gestures, self-checking.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_TICKS = 240;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [bcgd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [bcgd_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic                            pin_level;
	logic [bcgd_pkg::TIME_WIDTH-1:0] now_ms;
	logic                            out_valid;
	logic                            out_ready;
	logic                            rising;
	logic                            falling;
	logic                            click;
	logic                            double_click;
	logic                            long_press;
	logic                            pressed;

	button_click_gesture_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pin_level    (pin_level),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rising       (rising),
		.falling      (falling),
		.click        (click),
		.double_click (double_click),
		.long_press   (long_press),
		.pressed      (pressed)
	);

	// predictor state and register copies
	logic                                  was_down      = 1'b0;
	logic                                  is_down       = 1'b0;
	logic [1:0]                            releases      = 2'd0;
	logic [bcgd_pkg::HOLD_COUNT_WIDTH-1:0] hold_cnt      = '0;
	logic [bcgd_pkg::TIME_WIDTH-1:0]       gesture_start = '0;
	logic [bcgd_pkg::WIN_W-1:0]            win_ms        = bcgd_pkg::WIN_RESET;
	logic [bcgd_pkg::LPT_W-1:0]            lp_ticks      = bcgd_pkg::LPT_RESET;

	bcgd_pkg::gesture_t              gestures_due[$];
	logic [bcgd_pkg::TIME_WIDTH-1:0] clock_ms   = '0;
	int                              ticks_sent = 0;
	int                              faults     = 0;
	int                              cycle_count = 0;
	bit                              quiet      = 1'b0;

	typedef struct {
		logic                            pin;
		logic [bcgd_pkg::TIME_WIDTH-1:0] at;
		int                              reps;
		int                              stride;
		bit                              typed;
		bcgd_pkg::gesture_t              want;
	} script_row_t;

	// window 400 ms, long press at 4 held ticks
	script_row_t script [23] = '{
		'{1'b1, 32'd0,          1, 0,  1'b1, 6'b000000},
		'{1'b0, 32'd10,         1, 0,  1'b1, 6'b000001},
		'{1'b1, 32'd20,         1, 0,  1'b1, 6'b100000},
		'{1'b1, 32'd30,         1, 0,  1'b1, 6'b010000},
		'{1'b1, 32'd500,        1, 0,  1'b1, 6'b001000},
		'{1'b0, 32'd1000,       1, 0,  1'b1, 6'b000001},
		'{1'b1, 32'd1010,       1, 0,  1'b1, 6'b100000},
		'{1'b0, 32'd1020,       1, 0,  1'b1, 6'b010001},
		'{1'b1, 32'd1030,       1, 0,  1'b1, 6'b100000},
		'{1'b1, 32'd1040,       1, 0,  1'b1, 6'b010100},
		// hold past the long press, then a release that must not count
		'{1'b0, 32'd2000,       6, 10, 1'b0, 6'b000000},
		'{1'b1, 32'd3000,       2, 10, 1'b0, 6'b000000},
		// second release exactly on the window: dropped
		'{1'b0, 32'd4000,       1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'd4010,       1, 0,  1'b0, 6'b000000},
		'{1'b0, 32'd4020,       1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'd4030,       1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'd4410,       1, 0,  1'b0, 6'b000000},
		// double click across the timer wrap
		'{1'b0, 32'hFFFF_FFF0,  1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'hFFFF_FFF8,  1, 0,  1'b0, 6'b000000},
		'{1'b0, 32'hFFFF_FFFF,  1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'h0000_0005,  1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'h0000_0010,  1, 0,  1'b0, 6'b000000},
		'{1'b1, 32'hAAAA_5555,  1, 0,  1'b0, 6'b000000}
	};

	logic [bcgd_pkg::CFG_DATA_W-1:0] win_plan [6] =
		'{16'd400, 16'd0, 16'd32767, 16'hFFFF, 16'd37, 16'd100};
	logic [bcgd_pkg::CFG_DATA_W-1:0] lpt_plan [6] =
		'{16'd50, 16'd1, 16'd65534, 16'd12, 16'd0, 16'd3};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [bcgd_pkg::HOLD_COUNT_WIDTH-1:0] bump_hold(
		input logic [bcgd_pkg::HOLD_COUNT_WIDTH-1:0] h
	);
		return (&h) ? h : h + 1'b1;
	endfunction

	// advances the gesture state by one scan tick and returns the events it raises
	function automatic bcgd_pkg::gesture_t predict_gesture(
		input logic                            pin,
		input logic [bcgd_pkg::TIME_WIDTH-1:0] t
	);
		bcgd_pkg::gesture_t              g;
		logic [bcgd_pkg::TIME_WIDTH-1:0] span;
		g    = '0;
		span = t - gesture_start;
		if (!was_down && is_down) begin
			g.rising = 1'b1;
			if (releases == 2'd0)
				gesture_start = t;
		end else if (was_down && !is_down) begin
			if ({1'b0, hold_cnt} < {1'b0, lp_ticks} + 17'd1) begin
				releases  = releases + 2'd1;
				g.falling = 1'b1;
				if (releases == 2'd2) begin
					if (span < bcgd_pkg::TIME_WIDTH'(win_ms))
						g.double_click = 1'b1;
					releases = 2'd0;
				end
			end
			hold_cnt = '0;
		end else if (releases == 2'd1 && span > bcgd_pkg::TIME_WIDTH'(win_ms)) begin
			g.click  = 1'b1;
			releases = 2'd0;
		end
		if (hold_cnt == lp_ticks) begin
			hold_cnt     = bump_hold(hold_cnt);
			g.long_press = 1'b1;
		end
		was_down = is_down;
		is_down  = !pin;
		if (is_down)
			hold_cnt = bump_hold(hold_cnt);
		g.pressed = is_down;
		return g;
	endfunction

	// entered and left at a falling edge
	task automatic send_tick(
		input logic                            pin,
		input logic [bcgd_pkg::TIME_WIDTH-1:0] t,
		input bit                              typed,
		input bcgd_pkg::gesture_t              want
	);
		bcgd_pkg::gesture_t g;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid  = 1'b1;
		pin_level = pin;
		now_ms    = t;
		do @(posedge clk); while (!in_ready);
		g = predict_gesture(pin, t);
		if (typed)
			g = want;
		gestures_due.push_back(g);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input bcgd_pkg::cfg_reg_t idx,
		input logic [bcgd_pkg::CFG_DATA_W-1:0] val);
		in_valid = 1'b0;
		while (gestures_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == bcgd_pkg::REG_DBLCLICK_WINDOW)
			win_ms = val[bcgd_pkg::WIN_W-1:0];
		else
			lp_ticks = val[bcgd_pkg::LPT_W-1:0];
	endtask

	task automatic drive_level(input logic pin, input int n, input int max_step);
		repeat (n) begin
			clock_ms += $urandom_range(0, max_step);
			send_tick(pin, clock_ms, 1'b0, '0);
		end
	endtask

	task automatic play_gesture();
		int pace;
		int quick;
		int n;
		int pick;
		pace = int'(win_ms) / 8 + 1;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 19) == 0)
			clock_ms = $urandom();
		if (pick < 25) begin
			drive_level(1'b0, $urandom_range(1, 4), pace);
			drive_level(1'b1, $urandom_range(1, 3), pace);
			drive_level(1'b1, $urandom_range(1, 4), int'(win_ms) / 2 + 2);
		end else if (pick < 55) begin
			quick = ($urandom_range(0, 3) != 0) ? pace : int'(win_ms) + 2;
			drive_level(1'b0, $urandom_range(1, 3), quick);
			drive_level(1'b1, $urandom_range(1, 2), quick);
			drive_level(1'b0, $urandom_range(1, 3), quick);
			drive_level(1'b1, $urandom_range(1, 3), quick);
		end else if (pick < 70) begin
			// hold around the long press threshold
			n = int'(lp_ticks) + int'($urandom_range(0, 4)) - 1;
			if (n < 1)
				n = 1;
			if (n > 300)
				n = $urandom_range(1, 300);
			drive_level(1'b0, n, pace);
			drive_level(1'b1, $urandom_range(1, 3), pace);
		end else if (pick < 85) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(0, 5) == 0)
					clock_ms = $urandom();
				else
					clock_ms += $urandom_range(0, 2 * pace);
				send_tick(1'($urandom_range(0, 1)), clock_ms, 1'b0, '0);
			end
		end else begin
			drive_level(1'b1, $urandom_range(1, 3), 2 * int'(win_ms) + 20);
		end
	endtask

	task automatic check_bit(input string field, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", field, want, got);
			faults++;
		end
	endtask

	always @(posedge clk) begin : result_check
		bcgd_pkg::gesture_t want;
		if (arst_n && out_valid && out_ready) begin
			if (gestures_due.size() == 0) begin
				$error("result transfer with no result outstanding");
				faults++;
			end else begin
				want = gestures_due.pop_front();
				check_bit("rising", want.rising, rising);
				check_bit("falling", want.falling, falling);
				check_bit("click", want.click, click);
				check_bit("double_click", want.double_click, double_click);
				check_bit("long_press", want.long_press, long_press);
				check_bit("pressed", want.pressed, pressed);
			end
		end
	end

	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	initial begin : stimulus
		int target;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = bcgd_pkg::REG_DBLCLICK_WINDOW;
		cfg_data  = '0;
		in_valid  = 1'b0;
		pin_level = 1'b1;
		now_ms    = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(bcgd_pkg::REG_LONG_PRESS_TICKS, 16'd4);
		foreach (script[i])
			for (int r = 0; r < script[i].reps; r++)
				send_tick(script[i].pin,
					script[i].at + bcgd_pkg::TIME_WIDTH'(r * script[i].stride),
					script[i].typed, script[i].want);
		clock_ms = 32'hAAAA_5555;

		for (int p = 0; p < 6; p++) begin
			write_reg(bcgd_pkg::REG_DBLCLICK_WINDOW, win_plan[p]);
			write_reg(bcgd_pkg::REG_LONG_PRESS_TICKS, lpt_plan[p]);
			target = ticks_sent + PHASE_TICKS;
			while (ticks_sent < target)
				play_gesture();
		end

		// no idling from here on
		quiet = 1'b1;
		write_reg(bcgd_pkg::REG_DBLCLICK_WINDOW, 16'd400);
		write_reg(bcgd_pkg::REG_LONG_PRESS_TICKS, 16'd5);
		target = ticks_sent + 150;
		while (ticks_sent < target)
			play_gesture();

		in_valid = 1'b0;
		while (gestures_due.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		if (faults == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
